// ===== rtl/assert_macros.svh =====
// assertion macros shared by the checker modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold at every clock edge out of reset
`define RVFB_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("%m: assertion failed");

// implication checked in the cycle after the trigger
`define RVFB_ASSERT_NEXT(lbl, clk, rst_n, trig, res) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (res)) \
        else $error("%m: assertion failed one cycle after trigger");

`endif

// ===== rtl/rvfb_pkg.sv =====
// package with types, codes and sizes of the reverb filter blend block
`default_nettype none

package rvfb_pkg;

    // history ring and tap sizes
    localparam int HIST_DEPTH = 4096;
    localparam int HIST_AW    = $clog2(HIST_DEPTH);
    localparam int TAP_COUNT  = 64;
    localparam int TAP_AW     = (TAP_COUNT > 1) ? $clog2(TAP_COUNT) : 1;

    // accumulator and shared multiplier widths
    localparam int ACC_W  = 38;
    localparam int GAIN_W = 16;
    localparam int PROD_W = ACC_W + GAIN_W;

    // gain value of 1.0 in Q2.14
    localparam logic signed [15:0] GAIN_ONE = 16'sh4000;

    // item kinds
    localparam logic [1:0] KIND_SAMPLE = 2'd0;
    localparam logic [1:0] KIND_FILT   = 2'd1;
    localparam logic [1:0] KIND_REV    = 2'd2;

    // configuration register indexes
    localparam int CFG_AW = 2;
    localparam logic [CFG_AW-1:0] CFG_FILT_BASE = 2'd0;
    localparam logic [CFG_AW-1:0] CFG_FILT_EFF  = 2'd1;
    localparam logic [CFG_AW-1:0] CFG_REV_BASE  = 2'd2;
    localparam logic [CFG_AW-1:0] CFG_REV_EFF   = 2'd3;

    typedef struct packed {
        logic [1:0]         kind;
        logic signed [15:0] left_in;
        logic signed [15:0] right_in;
        logic [5:0]         coef_index;
        logic signed [15:0] coef_value;
    } t_in_item;

    typedef struct packed {
        logic signed [15:0] left_out;
        logic signed [15:0] right_out;
    } t_out_item;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_CHECK,
        S_MAC,
        S_DRAIN,
        S_EFF,
        S_BASEL,
        S_BASER,
        S_BLEND,
        S_DONE
    } t_state;

endpackage

`default_nettype wire

// ===== rtl/reverb_filter_fir_blend.sv =====
// two-stage stereo fir filter and sparse reverb with wet/dry blend, one shared mac
// after accept, an active stage reads all 64 taps through the history and tap memories
// into the one shared multiplier, drains the mac, then forms the effect and base products
// and blends; a bypassed stage is skipped; each sample item ends with the output load
// throughput: one item at a time; load items give no result
// reset: synchronous; a clearing pass zeroes all 4096 history entries and the taps
`default_nettype none

module reverb_filter_fir_blend (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_in_valid,
    output logic                             o_in_ready,
    input  wire rvfb_pkg::t_in_item          i_in_data,
    output logic                             o_out_valid,
    input  wire logic                        i_out_ready,
    output rvfb_pkg::t_out_item              o_out_data,
    input  wire logic                        i_cfg_valid,
    output logic                             o_cfg_ready,
    input  wire logic [rvfb_pkg::CFG_AW-1:0] i_cfg_index,
    input  wire logic [15:0]                 i_cfg_data
);
    import rvfb_pkg::*;

    t_state r_state, n_state;

    // configuration registers
    logic signed [15:0] r_filt_base, r_filt_eff, r_rev_base, r_rev_eff;

    // control state
    logic [HIST_AW-1:0] r_clr;
    logic [HIST_AW-1:0] r_pos;
    logic [TAP_AW-1:0]  r_tap;
    logic               r_stage;
    logic               r_rd_v;
    logic               r_mul_v;
    logic               r_out_valid;
    t_out_item          r_out_data;

    // datapath registers
    logic signed [15:0]       r_xl, r_xr;
    logic signed [ACC_W-1:0]  r_acc;
    logic signed [PROD_W-1:0] r_prod;
    logic signed [PROD_W-1:0] r_eff;
    logic signed [31:0]       r_pl;

    // memories and their registered read data
    logic signed [15:0] r_fhist [HIST_DEPTH];
    logic signed [15:0] r_rhist [HIST_DEPTH];
    logic signed [15:0] r_ftaps [TAP_COUNT];
    logic signed [15:0] r_rtaps [TAP_COUNT];
    logic signed [15:0] r_fh_q, r_rh_q, r_ft_q, r_rt_q;

    // control strobes
    logic w_clear, w_issue, w_blend, w_out_load, w_in_acc;
    logic w_tap_in_range;

    // datapath wires
    logic signed [15:0]       w_base, w_effect;
    logic                     w_bypass;
    logic [HIST_AW-1:0]       w_fdly, w_rdly, w_sq, w_fa, w_ra;
    logic [HIST_AW-1:0]       w_wr_addr;
    logic signed [15:0]       w_wr_data;
    logic [TAP_AW-1:0]        w_tap_addr;
    logic signed [15:0]       w_tap_data;
    logic signed [16:0]       w_mono_sum;
    logic signed [15:0]       w_mono;
    logic signed [15:0]       w_mul_a;
    logic signed [ACC_W-1:0]  w_mul_b;
    logic signed [15:0]       w_out_l, w_out_r;

    localparam logic signed [55:0] ROUND_HALF = 56'sd268435456;

    // (base*x*2^15 + eff + 2^28) >> 29, saturated to 16 bits
    function automatic logic signed [15:0] blend(input logic signed [31:0] pl,
                                                 input logic signed [PROD_W-1:0] eff);
        logic signed [55:0] sum;
        logic signed [26:0] sh;
        sum = 56'($signed({pl, 15'd0})) + 56'(eff) + ROUND_HALF;
        sh  = sum[55:29];
        if (sh > 27'sd32767) begin
            return 16'sh7fff;
        end else if (sh < -27'sd32768) begin
            return 16'sh8000;
        end
        return sh[15:0];
    endfunction

    // per-stage gains and bypass detect
    assign w_base   = r_stage ? r_rev_base : r_filt_base;
    assign w_effect = r_stage ? r_rev_eff  : r_filt_eff;
    assign w_bypass = (w_base == GAIN_ONE) && (w_effect == 16'sd0);

    // read addresses: filter delay t+1, reverb delay t*t+1
    assign w_sq   = HIST_AW'(r_tap) * HIST_AW'(r_tap);
    assign w_fdly = HIST_AW'(r_tap) + HIST_AW'(1);
    assign w_rdly = w_sq + HIST_AW'(1);
    assign w_fa   = r_pos - w_fdly;
    assign w_ra   = r_pos - w_rdly;

    // mono value of the stage input
    assign w_mono_sum = 17'(r_xl) + 17'(r_xr);
    assign w_mono     = w_mono_sum[16:1];

    assign w_out_l = blend(r_pl, r_eff);
    assign w_out_r = blend(r_prod[31:0], r_eff);

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR: begin
                if (r_clr == HIST_AW'(HIST_DEPTH - 1)) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (w_in_acc && i_in_data.kind == KIND_SAMPLE) n_state = S_CHECK;
            end
            S_CHECK: begin
                if (!w_bypass) n_state = S_MAC;
                else if (r_stage) n_state = S_DONE;
            end
            S_MAC: begin
                if (r_tap == TAP_AW'(TAP_COUNT - 1)) n_state = S_DRAIN;
            end
            S_DRAIN: begin
                if (!r_rd_v && !r_mul_v) n_state = S_EFF;
            end
            S_EFF:   n_state = S_BASEL;
            S_BASEL: n_state = S_BASER;
            S_BASER: n_state = S_BLEND;
            S_BLEND: begin
                n_state = r_stage ? S_DONE : S_CHECK;
            end
            S_DONE: begin
                if (w_out_load) n_state = S_IDLE;
            end
            default: n_state = S_CLEAR;
        endcase
    end

    // state-decoded strobes
    always_comb begin
        o_in_ready = 1'b0;
        w_clear    = 1'b0;
        w_issue    = 1'b0;
        w_blend    = 1'b0;
        w_out_load = 1'b0;
        case (r_state)
            S_CLEAR: w_clear    = 1'b1;
            S_IDLE:  o_in_ready = 1'b1;
            S_MAC:   w_issue    = 1'b1;
            S_BLEND: w_blend    = 1'b1;
            S_DONE:  w_out_load = !r_out_valid || i_out_ready;
            default: ;
        endcase
    end

    assign w_in_acc       = i_in_valid && o_in_ready;
    assign w_tap_in_range = int'(i_in_data.coef_index) < TAP_COUNT;
    assign o_cfg_ready    = 1'b1;
    assign o_out_valid    = r_out_valid;
    assign o_out_data     = r_out_data;

    // shared multiplier operand select
    always_comb begin
        case (r_state)
            S_EFF: begin
                w_mul_a = w_effect;
                w_mul_b = r_acc;
            end
            S_BASEL: begin
                w_mul_a = w_base;
                w_mul_b = ACC_W'(r_xl);
            end
            S_BASER: begin
                w_mul_a = w_base;
                w_mul_b = ACC_W'(r_xr);
            end
            default: begin
                w_mul_a = r_stage ? r_rt_q : r_ft_q;
                w_mul_b = r_stage ? ACC_W'(r_rh_q) : ACC_W'(r_fh_q);
            end
        endcase
    end

    // control registers and configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr       <= '0;
            r_pos       <= '0;
            r_tap       <= '0;
            r_stage     <= 1'b0;
            r_rd_v      <= 1'b0;
            r_mul_v     <= 1'b0;
            r_out_valid <= 1'b0;
            r_filt_base <= GAIN_ONE;
            r_filt_eff  <= 16'sd0;
            r_rev_base  <= GAIN_ONE;
            r_rev_eff   <= 16'sd0;
        end else begin
            r_state <= n_state;
            r_rd_v  <= w_issue;
            r_mul_v <= r_rd_v;
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    CFG_FILT_BASE: r_filt_base <= i_cfg_data;
                    CFG_FILT_EFF:  r_filt_eff  <= i_cfg_data;
                    CFG_REV_BASE:  r_rev_base  <= i_cfg_data;
                    CFG_REV_EFF:   r_rev_eff   <= i_cfg_data;
                    default: ;
                endcase
            end
            if (w_clear) r_clr <= r_clr + HIST_AW'(1);
            if (w_in_acc) r_stage <= 1'b0;
            if (r_state == S_CHECK) begin
                r_tap <= '0;
                if (w_bypass) r_stage <= 1'b1;
            end
            if (w_issue) r_tap <= r_tap + TAP_AW'(1);
            if (w_blend) r_stage <= 1'b1;
            if (w_out_load) begin
                r_pos       <= r_pos + HIST_AW'(1);
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // datapath: operands, mac, blend terms, result
    always_ff @(posedge i_clk) begin
        r_prod <= w_mul_a * w_mul_b;
        if (w_in_acc) begin
            r_xl <= i_in_data.left_in;
            r_xr <= i_in_data.right_in;
        end
        if (r_state == S_CHECK) r_acc <= '0;
        else if (r_mul_v) r_acc <= r_acc + r_prod[ACC_W-1:0];
        if (r_state == S_BASEL) r_eff <= r_prod;
        if (r_state == S_BASER) r_pl  <= r_prod[31:0];
        if (w_blend) begin
            r_xl <= w_out_l;
            r_xr <= w_out_r;
        end
        if (w_out_load) begin
            r_out_data.left_out  <= r_xl;
            r_out_data.right_out <= r_xr;
        end
    end

    // history write port: clearing pass or mono write at the write position
    assign w_wr_addr = w_clear ? r_clr : r_pos;
    assign w_wr_data = w_clear ? 16'sd0 : w_mono;

    always_ff @(posedge i_clk) begin
        if (w_clear || (w_blend && !r_stage)) r_fhist[w_wr_addr] <= w_wr_data;
        r_fh_q <= r_fhist[w_fa];
    end

    always_ff @(posedge i_clk) begin
        if (w_clear || (w_blend && r_stage)) r_rhist[w_wr_addr] <= w_wr_data;
        r_rh_q <= r_rhist[w_ra];
    end

    // tap write port: clearing pass or coefficient load
    assign w_tap_addr = w_clear ? r_clr[TAP_AW-1:0] : TAP_AW'(i_in_data.coef_index);
    assign w_tap_data = w_clear ? 16'sd0 : i_in_data.coef_value;

    always_ff @(posedge i_clk) begin
        if (w_clear || (w_in_acc && i_in_data.kind == KIND_FILT && w_tap_in_range)) begin
            r_ftaps[w_tap_addr] <= w_tap_data;
        end
        r_ft_q <= r_ftaps[r_tap];
    end

    always_ff @(posedge i_clk) begin
        if (w_clear || (w_in_acc && i_in_data.kind == KIND_REV && w_tap_in_range)) begin
            r_rtaps[w_tap_addr] <= w_tap_data;
        end
        r_rt_q <= r_rtaps[r_tap];
    end

endmodule

`default_nettype wire

// ===== rtl/rvfb_check.sv =====
// port-level assertion checker for the reverb filter blend block, with its bind
`default_nettype none
`include "assert_macros.svh"

module rvfb_check (
    input wire logic                i_clk,
    input wire logic                i_rst_n,
    input wire logic                i_in_valid,
    input wire logic                o_in_ready,
    input wire rvfb_pkg::t_in_item  i_in_data,
    input wire logic                o_out_valid,
    input wire logic                i_out_ready,
    input wire rvfb_pkg::t_out_item o_out_data,
    input wire logic                o_cfg_ready
);
    import rvfb_pkg::*;

    // a waiting result stays offered
    `RVFB_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready, o_out_valid)

    // a waiting result keeps its value
    `RVFB_ASSERT_NEXT(a_out_stable, i_clk, i_rst_n, o_out_valid && !i_out_ready, $stable(o_out_data))

    // a sample item closes the input once it is taken
    `RVFB_ASSERT_NEXT(a_sample_busy, i_clk, i_rst_n, i_in_valid && o_in_ready && i_in_data.kind == KIND_SAMPLE, !o_in_ready)

    // a load item never makes a result appear
    `RVFB_ASSERT_NEXT(a_load_quiet, i_clk, i_rst_n, i_in_valid && o_in_ready && i_in_data.kind != KIND_SAMPLE && !o_out_valid, !o_out_valid)

    // configuration writes are always taken
    `RVFB_ASSERT(a_cfg_open, i_clk, i_rst_n, o_cfg_ready)

endmodule

bind reverb_filter_fir_blend rvfb_check u_rvfb_check (.*);

`default_nettype wire

// ===== tb/reverb_filter_fir_blend_tb.sv =====
// self-checking testbench for the two-stage fir filter and sparse reverb blend block
module reverb_filter_fir_blend_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import rvfb_pkg::*;

    // kind value with no meaning, must be dropped by the block
    localparam logic [1:0] KIND_UNUSED = 2'd3;
    // cycles to wait after the last result so a trailing load item settles
    localparam int DRAIN_CYCLES = 300;
    localparam int LIMIT_CYCLES = 1000000;
    localparam int PHASE_ITEMS = 140;
    localparam int IDLE_PCT = 28;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_in_valid = 1'b0;
    logic                 o_in_ready;
    t_in_item             i_in_data = '0;
    logic                 o_out_valid;
    logic                 i_out_ready = 1'b0;
    t_out_item            o_out_data;
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [CFG_AW-1:0]    i_cfg_index = '0;
    logic [15:0]          i_cfg_data = '0;

    // predicted block state
    bit signed [15:0]     filt_hist [HIST_DEPTH];
    bit signed [15:0]     rev_hist [HIST_DEPTH];
    bit signed [15:0]     filt_taps [TAP_COUNT];
    bit signed [15:0]     rev_taps [TAP_COUNT];
    bit [HIST_AW-1:0]     write_pos;
    logic signed [15:0]   filt_base = GAIN_ONE;
    logic signed [15:0]   filt_eff = 16'sd0;
    logic signed [15:0]   rev_base = GAIN_ONE;
    logic signed [15:0]   rev_eff = 16'sd0;

    t_in_item             queued_items [$];
    t_out_item            expected_samples [$];
    int                   mismatch_count = 0;
    int                   cycle_count = 0;
    bit                   no_idle = 1'b0;

    reverb_filter_fir_blend dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // clock
    always #5 i_clk = ~i_clk;

    function automatic logic signed [15:0] sat16(input longint v);
        if (v > 32767) return 16'sh7fff;
        if (v < -32768) return 16'sh8000;
        return 16'(v);
    endfunction

    // one stage: skipped when bypassed, else fir sum over history, blend with dry input, then history write
    function automatic void run_stage(input bit sparse, input logic signed [15:0] base,
                                      input logic signed [15:0] eff,
                                      inout logic signed [15:0] l,
                                      inout logic signed [15:0] r);
        longint acc = 0;
        longint wet;
        longint dry_l;
        longint dry_r;
        logic [HIST_AW-1:0] rd_pos;
        logic signed [15:0] tap;
        logic signed [15:0] hval;
        logic signed [16:0] mono_sum;
        if (base == GAIN_ONE && eff == 16'sd0) return;
        for (int t = 0; t < TAP_COUNT; t++) begin
            rd_pos = write_pos - HIST_AW'(sparse ? t * t + 1 : t + 1);
            tap = sparse ? rev_taps[t] : filt_taps[t];
            hval = sparse ? rev_hist[rd_pos] : filt_hist[rd_pos];
            acc += longint'(tap) * longint'(hval);
        end
        mono_sum = l + r;
        wet = longint'(eff) * acc;
        dry_l = longint'(base) * longint'(l) * 32768;
        dry_r = longint'(base) * longint'(r) * 32768;
        l = sat16((dry_l + wet + 268435456) >>> 29);
        r = sat16((dry_r + wet + 268435456) >>> 29);
        if (sparse) rev_hist[write_pos] = mono_sum[16:1];
        else filt_hist[write_pos] = mono_sum[16:1];
    endfunction

    // update predicted state for an accepted item, queue the expected sample
    function automatic void predict_blend(input t_in_item it);
        logic signed [15:0] l;
        logic signed [15:0] r;
        t_out_item res;
        case (it.kind)
            KIND_FILT: filt_taps[it.coef_index] = it.coef_value;
            KIND_REV:  rev_taps[it.coef_index] = it.coef_value;
            KIND_SAMPLE: begin
                l = it.left_in;
                r = it.right_in;
                run_stage(1'b0, filt_base, filt_eff, l, r);
                run_stage(1'b1, rev_base, rev_eff, l, r);
                write_pos = write_pos + 1'b1;
                res.left_out = l;
                res.right_out = r;
                expected_samples.push_back(res);
            end
            default: ;
        endcase
    endfunction

    // value around zero within +/- span
    function automatic logic signed [15:0] rand_near(input int span);
        int v;
        v = int'($urandom_range(2 * span)) - span;
        return 16'(v);
    endfunction

    function automatic logic signed [15:0] rand_audio();
        case ($urandom_range(3))
            0, 1: return 16'($urandom);
            2: return rand_near(2048);
            default: begin
                case ($urandom_range(3))
                    0: return 16'sh7fff;
                    1: return 16'sh8000;
                    2: return 16'sd0;
                    default: return -16'sd1;
                endcase
            end
        endcase
    endfunction

    function automatic logic signed [15:0] rand_gain();
        case ($urandom_range(9))
            0: return 16'($urandom);
            1: return GAIN_ONE;
            2: return 16'sd0;
            default: return rand_near(8192);
        endcase
    endfunction

    function automatic logic signed [15:0] rand_coef();
        return $urandom_range(1) ? 16'($urandom) : rand_near(2048);
    endfunction

    function automatic t_in_item make_sample(input logic signed [15:0] l,
                                             input logic signed [15:0] r);
        t_in_item it;
        it.kind = KIND_SAMPLE;
        it.left_in = l;
        it.right_in = r;
        it.coef_index = 6'($urandom);
        it.coef_value = 16'($urandom);
        return it;
    endfunction

    function automatic t_in_item make_load(input logic [1:0] kind, input int idx,
                                           input logic signed [15:0] val);
        t_in_item it;
        it.kind = kind;
        it.left_in = 16'($urandom);
        it.right_in = 16'($urandom);
        it.coef_index = 6'(idx);
        it.coef_value = val;
        return it;
    endfunction

    function automatic t_in_item rand_item();
        t_in_item it;
        int unsigned pick;
        it.left_in = rand_audio();
        it.right_in = rand_audio();
        it.coef_index = 6'($urandom);
        it.coef_value = rand_coef();
        pick = $urandom_range(99);
        if (pick < 70) it.kind = KIND_SAMPLE;
        else if (pick < 82) it.kind = KIND_FILT;
        else if (pick < 94) it.kind = KIND_REV;
        else it.kind = KIND_UNUSED;
        return it;
    endfunction

    // item sender: holds valid until accepted, random gaps between items
    always @(posedge i_clk) begin : sender
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && o_in_ready) begin
                predict_blend(i_in_data);
            end
            if (!i_in_valid || o_in_ready) begin
                if (queued_items.size() > 0 &&
                    (no_idle || $urandom_range(99) >= IDLE_PCT)) begin
                    i_in_valid <= 1'b1;
                    i_in_data <= queued_items.pop_front();
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // result receiver and checker with random stalls
    always @(posedge i_clk) begin : receiver
        t_out_item want;
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                if (expected_samples.size() == 0) begin
                    if (mismatch_count < 10)
                        $display("unexpected item: l=%0d r=%0d",
                                 o_out_data.left_out, o_out_data.right_out);
                    mismatch_count++;
                end else begin
                    want = expected_samples.pop_front();
                    if (o_out_data.left_out !== want.left_out ||
                        o_out_data.right_out !== want.right_out) begin
                        if (mismatch_count < 10)
                            $display("mismatch: expected l=%0d r=%0d, got l=%0d r=%0d",
                                     want.left_out, want.right_out,
                                     o_out_data.left_out, o_out_data.right_out);
                        mismatch_count++;
                    end
                end
            end
            i_out_ready <= no_idle || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    // run limit
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > LIMIT_CYCLES) begin
            $display("reverb_filter_fir_blend_tb: FAIL");
            $finish;
        end
    end

    // wait until every queued item is accepted and every sample has come back
    task automatic wait_drained();
        while (queued_items.size() > 0 || i_in_valid || expected_samples.size() > 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_gain(input logic [CFG_AW-1:0] idx, input logic signed [15:0] val);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        case (idx)
            CFG_FILT_BASE: filt_base = val;
            CFG_FILT_EFF:  filt_eff = val;
            CFG_REV_BASE:  rev_base = val;
            CFG_REV_EFF:   rev_eff = val;
            default: ;
        endcase
    endtask

    task automatic set_gains(input logic signed [15:0] fb, input logic signed [15:0] fe,
                             input logic signed [15:0] rb, input logic signed [15:0] re);
        wait_drained();
        write_gain(CFG_FILT_BASE, fb);
        write_gain(CFG_FILT_EFF, fe);
        write_gain(CFG_REV_BASE, rb);
        write_gain(CFG_REV_EFF, re);
    endtask

    // queue random items until count meaningful ones are in
    task automatic queue_random(input int count);
        t_in_item it;
        int n;
        n = 0;
        while (n < count) begin
            it = rand_item();
            queued_items.push_back(it);
            if (it.kind != KIND_UNUSED) n++;
        end
    endtask

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset gains bypass both stages
        queued_items.push_back(make_sample(16'sh7fff, 16'sh8000));
        queued_items.push_back(make_sample(-16'sd1, 16'sd0));
        queued_items.push_back(make_sample(16'sd100, -16'sd100));

        // directed: tap extremes, unused kind, sample extremes and mono rounding
        set_gains(GAIN_ONE, GAIN_ONE, GAIN_ONE, 16'sd8192);
        queued_items.push_back(make_load(KIND_FILT, 0, 16'sh7fff));
        queued_items.push_back(make_load(KIND_FILT, 63, 16'sh8000));
        queued_items.push_back(make_load(KIND_FILT, 1, -16'sd16384));
        queued_items.push_back(make_load(KIND_REV, 0, 16'sh8000));
        queued_items.push_back(make_load(KIND_REV, 63, 16'sh7fff));
        queued_items.push_back(make_load(KIND_REV, 1, 16'sd12345));
        queued_items.push_back(make_load(KIND_UNUSED, 2, 16'sh7fff));
        queued_items.push_back(make_sample(16'sh7fff, 16'sh7fff));
        queued_items.push_back(make_sample(16'sh8000, 16'sh8000));
        queued_items.push_back(make_sample(16'sh7fff, 16'sh8000));
        queued_items.push_back(make_sample(16'sh8000, 16'sh7fff));
        queued_items.push_back(make_sample(-16'sd1, -16'sd1));
        queued_items.push_back(make_sample(-16'sd1, 16'sd0));
        queued_items.push_back(make_sample(16'sd0, 16'sd0));
        queued_items.push_back(make_sample(16'sd1, 16'sd0));
        queued_items.push_back(make_sample(16'sd12345, -16'sd222));

        // random phases, each under its own gain setting
        set_gains(rand_gain(), rand_near(8192), rand_gain(), rand_near(8192));
        queue_random(PHASE_ITEMS);

        // gain extremes, sender holds off once mid phase
        set_gains(16'sh8000, 16'sh7fff, 16'sh7fff, 16'sh8000);
        queue_random(PHASE_ITEMS / 2);
        wait_drained();
        queue_random(PHASE_ITEMS / 2);

        // zero filter gains still write history; no idling on either side
        set_gains(16'sd0, 16'sd0, rand_gain(), rand_near(8192));
        no_idle = 1'b1;
        queue_random(PHASE_ITEMS);
        wait_drained();
        no_idle = 1'b0;

        // filter bypassed, reverb alone
        set_gains(GAIN_ONE, 16'sd0, rand_near(16384), rand_near(8192));
        queue_random(PHASE_ITEMS);

        // reverb bypassed, filter alone
        set_gains(rand_near(16384), rand_near(8192), GAIN_ONE, 16'sd0);
        queue_random(PHASE_ITEMS);

        // full range gains
        set_gains(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
        queue_random(PHASE_ITEMS);

        wait_drained();
        if (mismatch_count == 0 && expected_samples.size() == 0) begin
            $display("reverb_filter_fir_blend_tb: PASS");
        end else begin
            $display("reverb_filter_fir_blend_tb: FAIL");
        end
        $finish;
    end

endmodule
